// File: rtl/pgf_pkg.sv
// ----------------------------------------------------------------------------
// Pairwise gravity force package
// Shared widths, latencies and beat types for the pairwise gravity force block.
// ----------------------------------------------------------------------------
package pgf_pkg;

    localparam int POS_W   = 32;
    localparam int MASS_W  = 32;
    localparam int GRAV_W  = 32;
    localparam int FORCE_W = 48;
    localparam int MAG_W   = 32;
    localparam int SUM_W   = 66;
    localparam int ROOT_W  = 33;
    localparam int PROD_W  = 96;
    localparam int NUM_W   = 128;
    localparam int DEN_W   = 99;
    localparam int QUO_W   = 47;
    localparam int MUL_LAT = 2;

    localparam logic [GRAV_W-1:0] GRAV_RESET = 32'd65536;

    typedef struct packed {
        logic signed [POS_W-1:0] first_x;
        logic signed [POS_W-1:0] first_y;
        logic signed [POS_W-1:0] first_z;
        logic        [MASS_W-1:0] first_mass;
        logic signed [POS_W-1:0] second_x;
        logic signed [POS_W-1:0] second_y;
        logic signed [POS_W-1:0] second_z;
        logic        [MASS_W-1:0] second_mass;
    } t_pair_in;

    typedef struct packed {
        logic signed [FORCE_W-1:0] pull_one_x;
        logic signed [FORCE_W-1:0] pull_one_y;
        logic signed [FORCE_W-1:0] pull_one_z;
        logic signed [FORCE_W-1:0] pull_two_x;
        logic signed [FORCE_W-1:0] pull_two_y;
        logic signed [FORCE_W-1:0] pull_two_z;
        logic                      coincident;
        logic                      saturated;
    } t_pair_out;

endpackage

// File: rtl/pgf_mul.sv
// ----------------------------------------------------------------------------
// Pipelined wide multiplier
// Splits the wide operand into 32-bit chunks, registers the partial products,
// then sums them in a second stage.
// ----------------------------------------------------------------------------
module pgf_mul #(
    parameter int WA = 64,
    parameter int WB = 32
) (
    input  logic               i_clk,
    input  logic [WA-1:0]      i_a,
    input  logic [WB-1:0]      i_b,
    output logic [WA+WB-1:0]   o_p
);
    localparam int NC = (WA + 31) / 32;
    localparam int WP = 32 + WB;

    logic [NC*32-1:0]   a_pad;
    logic [WP-1:0]      r_pp [NC];
    logic [WA+WB-1:0]   n_p;
    logic [WA+WB-1:0]   r_p;

    assign a_pad = (NC*32)'(i_a);

    always_ff @(posedge i_clk) begin
        for (int i = 0; i < NC; i++) begin
            r_pp[i] <= WP'(a_pad[i*32 +: 32]) * WP'(i_b);
        end
    end

    // Chunk products are placed at their weight and added up.
    always_comb begin
        n_p = '0;
        for (int i = 0; i < NC; i++) begin
            n_p = n_p + ((WA+WB)'(r_pp[i]) << (32*i));
        end
    end

    always_ff @(posedge i_clk) begin
        r_p <= n_p;
    end

    assign o_p = r_p;

endmodule

// File: rtl/pgf_dly.sv
// ----------------------------------------------------------------------------
// Payload delay line
// Fixed-depth shift register that keeps side data aligned with the pipeline.
// ----------------------------------------------------------------------------
module pgf_dly #(
    parameter int W     = 8,
    parameter int DEPTH = 1
) (
    input  logic         i_clk,
    input  logic [W-1:0] i_d,
    output logic [W-1:0] o_d
);
    logic [W-1:0] r_tap [DEPTH];

    always_ff @(posedge i_clk) begin
        r_tap[0] <= i_d;
        for (int i = 1; i < DEPTH; i++) begin
            r_tap[i] <= r_tap[i-1];
        end
    end

    assign o_d = r_tap[DEPTH-1];

endmodule

// File: rtl/pgf_sqrt.sv
// ----------------------------------------------------------------------------
// Pipelined integer square root
// One result bit per stage; the remainder s - root^2 travels with the root.
// ----------------------------------------------------------------------------
module pgf_sqrt #(
    parameter int WI = 66,
    parameter int WO = 33
) (
    input  logic          i_clk,
    input  logic [WI-1:0] i_s,
    output logic [WO-1:0] o_root
);
    localparam int WT = WI + 2;

    logic [WI-1:0] r_rem [WO];
    logic [WO-1:0] r_res [WO];

    for (genvar i = 0; i < WO; i++) begin : g_stage
        localparam int B = WO - 1 - i;
        logic [WI-1:0] rem_in;
        logic [WO-1:0] res_in;
        logic [WT-1:0] trial;

        if (i == 0) begin : g_first
            assign rem_in = i_s;
            assign res_in = '0;
        end else begin : g_next
            assign rem_in = r_rem[i-1];
            assign res_in = r_res[i-1];
        end

        // Setting bit B grows root^2 by 2*root*2^B + 2^(2B).
        assign trial = (WT'(res_in) << (B + 1)) | (WT'(1) << (2 * B));

        always_ff @(posedge i_clk) begin
            if (WT'(rem_in) >= trial) begin
                r_rem[i] <= WI'(WT'(rem_in) - trial);
                r_res[i] <= res_in | (WO'(1) << B);
            end else begin
                r_rem[i] <= rem_in;
                r_res[i] <= res_in;
            end
        end
    end

    assign o_root = r_res[WO-1];

endmodule

// File: rtl/pgf_div.sv
// ----------------------------------------------------------------------------
// Pipelined restoring divider with overflow detect
// The first stage flags quotients of 2^WQ or more; then one bit per stage.
// ----------------------------------------------------------------------------
module pgf_div #(
    parameter int WN = 128,
    parameter int WD = 99,
    parameter int WQ = 47
) (
    input  logic          i_clk,
    input  logic [WN-1:0] i_n,
    input  logic [WD-1:0] i_d,
    output logic [WQ-1:0] o_q,
    output logic          o_ovf
);
    localparam int WR = WD + WQ;

    logic [WR-1:0] r_rem [WQ+1];
    logic [WD-1:0] r_dv  [WQ+1];
    logic [WQ-1:0] r_q   [WQ+1];
    logic          r_ovf [WQ+1];

    always_ff @(posedge i_clk) begin
        r_rem[0] <= WR'(i_n);
        r_dv[0]  <= i_d;
        r_q[0]   <= '0;
        r_ovf[0] <= WR'(i_n) >= (WR'(i_d) << WQ);
    end

    for (genvar j = 1; j <= WQ; j++) begin : g_stage
        localparam int B = WQ - j;
        logic [WR-1:0] trial;

        assign trial = WR'(r_dv[j-1]) << B;

        always_ff @(posedge i_clk) begin
            r_dv[j]  <= r_dv[j-1];
            r_ovf[j] <= r_ovf[j-1];
            if (r_rem[j-1] >= trial) begin
                r_rem[j] <= r_rem[j-1] - trial;
                r_q[j]   <= r_q[j-1] | (WQ'(1) << B);
            end else begin
                r_rem[j] <= r_rem[j-1];
                r_q[j]   <= r_q[j-1];
            end
        end
    end

    assign o_q   = r_q[WQ];
    assign o_ovf = r_ovf[WQ];

endmodule

// File: rtl/pairwise_gravity_force.sv
// ----------------------------------------------------------------------------
// Pairwise gravity force
// Newtonian attraction between two bodies, fixed point, one pair per cycle.
// ----------------------------------------------------------------------------
// A pair beat is taken on every clock edge at which start is high; busy is
// always low because the pipeline never stalls, so a new pair may follow in
// the very next cycle. Each pair yields one result beat on o_result, marked
// by o_valid for exactly one cycle. The latency is set by the 33-stage square
// root, the divisor multiplier and the 48-stage divider that sit in series
// in the pipeline; throughput is one pair per cycle.
// The receiver cannot hold results off, so beats simply leave in order.
// Synchronous reset clears all valid bits and loads G with 1.0; data in
// flight is dropped. The G register is written through i_cfg_we and
// i_cfg_wdata and should only change while no pair is in flight.
// Coincident bodies give zero force with the coincident flag set; a force
// magnitude above 2^47-1 is clamped and raises the saturated flag.
// ----------------------------------------------------------------------------
module pairwise_gravity_force
    import pgf_pkg::*;
(
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  logic              start,
    output logic              busy,
    input  t_pair_in          i_pair,
    input  logic              i_cfg_we,
    input  logic [GRAV_W-1:0] i_cfg_wdata,
    output logic              o_valid,
    output t_pair_out         o_result
);
    // Cycle at which each quantity is available as a register output,
    // counted from the accepting edge.
    localparam int T_S    = 3;
    localparam int T_PROD = 2 + MUL_LAT;
    localparam int T_NUM  = T_PROD + MUL_LAT;
    localparam int T_ROOT = T_S + ROOT_W;
    localparam int T_DEN  = T_ROOT + MUL_LAT;
    localparam int T_Q    = T_DEN + QUO_W + 1;

    logic [GRAV_W-1:0] r_grav;

    // The register takes G whenever the write enable is high and reset is not asserted.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_grav <= GRAV_RESET;
        end else if (i_cfg_we) begin
            r_grav <= i_cfg_wdata;
        end
    end

    assign busy = 1'b0;

    // Valid bits travel alongside the data; bit k is the beat at cycle k.
    logic [T_Q:1] r_vld;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_vld <= '0;
        end else begin
            r_vld <= {r_vld[T_Q-1:1], start};
        end
    end

    // Stage 1: difference vector, split into magnitude and sign.
    logic [POS_W:0]     d     [3];
    logic [POS_W:0]     d_abs [3];
    logic [MAG_W-1:0]   r1_mag [3];
    logic [2:0]         r1_sgn;
    logic               r1_coin;
    logic [MASS_W-1:0]  r1_m1;
    logic [MASS_W-1:0]  r1_m2;

    assign d[0] = {i_pair.second_x[POS_W-1], i_pair.second_x}
                - {i_pair.first_x[POS_W-1], i_pair.first_x};
    assign d[1] = {i_pair.second_y[POS_W-1], i_pair.second_y}
                - {i_pair.first_y[POS_W-1], i_pair.first_y};
    assign d[2] = {i_pair.second_z[POS_W-1], i_pair.second_z}
                - {i_pair.first_z[POS_W-1], i_pair.first_z};

    always_comb begin
        for (int k = 0; k < 3; k++) begin
            d_abs[k] = d[k][POS_W] ? -d[k] : d[k];
        end
    end

    always_ff @(posedge i_clk) begin
        for (int k = 0; k < 3; k++) begin
            r1_mag[k] <= d_abs[k][MAG_W-1:0];
            r1_sgn[k] <= d[k][POS_W];
        end
        r1_coin <= (d[0] == '0) && (d[1] == '0) && (d[2] == '0);
        r1_m1   <= i_pair.first_mass;
        r1_m2   <= i_pair.second_mass;
    end

    // Stage 2: squares of the components and G*m1.
    logic [2*MAG_W-1:0]       r2_sq [3];
    logic [GRAV_W+MASS_W-1:0] r2_gm;
    logic [MASS_W-1:0]        r2_m2;

    always_ff @(posedge i_clk) begin
        for (int k = 0; k < 3; k++) begin
            r2_sq[k] <= r1_mag[k] * r1_mag[k];
        end
        r2_gm <= (GRAV_W+MASS_W)'(r_grav) * (GRAV_W+MASS_W)'(r1_m1);
        r2_m2 <= r1_m2;
    end

    // Stage 3: squared distance.
    logic [SUM_W-1:0] r3_s;

    always_ff @(posedge i_clk) begin
        r3_s <= SUM_W'(r2_sq[0]) + SUM_W'(r2_sq[1]) + SUM_W'(r2_sq[2]);
    end

    // P = G*m1*m2 as a full 96-bit product.
    logic [PROD_W-1:0] prod;

    pgf_mul #(
        .WA(GRAV_W + MASS_W),
        .WB(MASS_W)
    ) u_prod (
        .i_clk (i_clk),
        .i_a   (r2_gm),
        .i_b   (r2_m2),
        .o_p   (prod)
    );

    // Component magnitudes wait for P, then each numerator is P*|d|.
    logic [3*MAG_W-1:0] mag_p;
    logic [NUM_W-1:0]   num [3];
    logic [3*NUM_W-1:0] num_d;

    pgf_dly #(
        .W    (3 * MAG_W),
        .DEPTH(T_PROD - 1)
    ) u_mag_dly (
        .i_clk (i_clk),
        .i_d   ({r1_mag[2], r1_mag[1], r1_mag[0]}),
        .o_d   (mag_p)
    );

    for (genvar k = 0; k < 3; k++) begin : g_num
        logic [PROD_W+MAG_W-1:0] num_full;

        pgf_mul #(
            .WA(PROD_W),
            .WB(MAG_W)
        ) u_num (
            .i_clk (i_clk),
            .i_a   (prod),
            .i_b   (mag_p[k*MAG_W +: MAG_W]),
            .o_p   (num_full)
        );

        assign num[k] = num_full[NUM_W-1:0];
    end

    pgf_dly #(
        .W    (3 * NUM_W),
        .DEPTH(T_DEN - T_NUM)
    ) u_num_dly (
        .i_clk (i_clk),
        .i_d   ({num[2], num[1], num[0]}),
        .o_d   (num_d)
    );

    // Distance r = floor(sqrt(s)); the divisor is s*r.
    logic [ROOT_W-1:0] root;
    logic [SUM_W-1:0]  s_d;
    logic [DEN_W-1:0]  den;

    pgf_sqrt #(
        .WI(SUM_W),
        .WO(ROOT_W)
    ) u_sqrt (
        .i_clk  (i_clk),
        .i_s    (r3_s),
        .o_root (root)
    );

    pgf_dly #(
        .W    (SUM_W),
        .DEPTH(T_ROOT - T_S)
    ) u_s_dly (
        .i_clk (i_clk),
        .i_d   (r3_s),
        .o_d   (s_d)
    );

    pgf_mul #(
        .WA(SUM_W),
        .WB(ROOT_W)
    ) u_den (
        .i_clk (i_clk),
        .i_a   (s_d),
        .i_b   (root),
        .o_p   (den)
    );

    // Force magnitude per component. With coincident bodies the divisor is
    // zero and the quotient is meaningless; the output stage masks it.
    logic [QUO_W-1:0] quo [3];
    logic [2:0]       ovf;

    for (genvar k = 0; k < 3; k++) begin : g_div
        pgf_div #(
            .WN(NUM_W),
            .WD(DEN_W),
            .WQ(QUO_W)
        ) u_div (
            .i_clk (i_clk),
            .i_n   (num_d[k*NUM_W +: NUM_W]),
            .i_d   (den),
            .o_q   (quo[k]),
            .o_ovf (ovf[k])
        );
    end

    // Signs and the coincident flag ride along to the output stage.
    logic [3:0] flags_q;

    pgf_dly #(
        .W    (4),
        .DEPTH(T_Q - 1)
    ) u_flag_dly (
        .i_clk (i_clk),
        .i_d   ({r1_coin, r1_sgn}),
        .o_d   (flags_q)
    );

    // Output stage: clamp, apply the sign of d, and negate for body two.
    logic [FORCE_W-1:0] one_f [3];
    logic [FORCE_W-1:0] two_f [3];
    logic [FORCE_W-1:0] mag_f;
    t_pair_out          n_result;
    t_pair_out          r_result;
    logic               r_valid;

    always_comb begin
        for (int k = 0; k < 3; k++) begin
            mag_f    = ovf[k] ? {1'b0, {QUO_W{1'b1}}} : {1'b0, quo[k]};
            one_f[k] = flags_q[3] ? '0 : (flags_q[k] ? -mag_f : mag_f);
            two_f[k] = -one_f[k];
        end
        n_result.pull_one_x = one_f[0];
        n_result.pull_one_y = one_f[1];
        n_result.pull_one_z = one_f[2];
        n_result.pull_two_x = two_f[0];
        n_result.pull_two_y = two_f[1];
        n_result.pull_two_z = two_f[2];
        n_result.coincident = flags_q[3];
        n_result.saturated  = !flags_q[3] && (ovf != '0);
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= 1'b0;
        end else begin
            r_valid <= r_vld[T_Q];
        end
    end

    always_ff @(posedge i_clk) begin
        r_result <= n_result;
    end

    assign o_valid  = r_valid;
    assign o_result = r_result;

endmodule

// File: bench/pairwise_gravity_force_tb.sv
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// Pairwise gravity force testbench
// Drives body pairs with random idle gaps and several values of G, predicts
// each force beat with exact wide integer arithmetic and checks every field.
// ----------------------------------------------------------------------------
module pairwise_gravity_force_tb;
    import pgf_pkg::*;

    localparam logic [FORCE_W-1:0] FORCE_CLAMP = {1'b0, {(FORCE_W-1){1'b1}}};
    localparam int DRAIN_CYCLES = 120;
    localparam int WATCHDOG_LIMIT = 2000;

    // Predicts the force beat for a pair under a given G, holds the beats
    // still to come and compares each arriving beat with the oldest one.
    class force_scoreboard;
        t_pair_out pending_forces[$];
        logic [GRAV_W-1:0] grav;
        int errors;

        function void note_pair(t_pair_in p);
            logic signed [POS_W:0] delta[3];
            logic [POS_W:0] mag[3];
            logic [SUM_W-1:0] dist_sq;
            logic [ROOT_W-1:0] root;
            logic [ROOT_W-1:0] trial;
            logic [PROD_W-1:0] grav_mm;
            logic [NUM_W-1:0] num;
            logic [NUM_W-1:0] den;
            logic [NUM_W-1:0] quo;
            logic [FORCE_W-1:0] m;
            t_pair_out res;
            delta[0] = {p.second_x[POS_W-1], p.second_x} - {p.first_x[POS_W-1], p.first_x};
            delta[1] = {p.second_y[POS_W-1], p.second_y} - {p.first_y[POS_W-1], p.first_y};
            delta[2] = {p.second_z[POS_W-1], p.second_z} - {p.first_z[POS_W-1], p.first_z};
            dist_sq = '0;
            for (int k = 0; k < 3; k++) begin
                mag[k] = delta[k][POS_W] ? -delta[k] : delta[k];
                dist_sq += SUM_W'(mag[k]) * SUM_W'(mag[k]);
            end
            res = '0;
            if (dist_sq == 0) begin
                res.coincident = 1'b1;
            end else begin
                // Floor square root, one bit at a time from the top.
                root = '0;
                for (int b = ROOT_W-1; b >= 0; b--) begin
                    trial = root | (ROOT_W'(1) << b);
                    if (SUM_W'(trial) * SUM_W'(trial) <= dist_sq)
                        root = trial;
                end
                grav_mm = PROD_W'(grav) * PROD_W'(p.first_mass) * PROD_W'(p.second_mass);
                den = NUM_W'(dist_sq) * NUM_W'(root);
                for (int k = 0; k < 3; k++) begin
                    num = NUM_W'(grav_mm) * NUM_W'(mag[k]);
                    quo = num / den;
                    if (quo > NUM_W'(FORCE_CLAMP)) begin
                        m = FORCE_CLAMP;
                        res.saturated = 1'b1;
                    end else begin
                        m = quo[FORCE_W-1:0];
                    end
                    // The force on body one points toward body two.
                    if (delta[k][POS_W]) m = -m;
                    case (k)
                        0: begin res.pull_one_x = m; res.pull_two_x = -m; end
                        1: begin res.pull_one_y = m; res.pull_two_y = -m; end
                        default: begin res.pull_one_z = m; res.pull_two_z = -m; end
                    endcase
                end
            end
            pending_forces.push_back(res);
        endfunction

        task check_force(t_pair_out got);
            t_pair_out exp;
            if (pending_forces.size() == 0) begin
                report_mismatch("force beat with no pair waiting", 0, 1);
            end else begin
                exp = pending_forces.pop_front();
                if (got.pull_one_x !== exp.pull_one_x)
                    report_mismatch("pull_one_x", got.pull_one_x, exp.pull_one_x);
                if (got.pull_one_y !== exp.pull_one_y)
                    report_mismatch("pull_one_y", got.pull_one_y, exp.pull_one_y);
                if (got.pull_one_z !== exp.pull_one_z)
                    report_mismatch("pull_one_z", got.pull_one_z, exp.pull_one_z);
                if (got.pull_two_x !== exp.pull_two_x)
                    report_mismatch("pull_two_x", got.pull_two_x, exp.pull_two_x);
                if (got.pull_two_y !== exp.pull_two_y)
                    report_mismatch("pull_two_y", got.pull_two_y, exp.pull_two_y);
                if (got.pull_two_z !== exp.pull_two_z)
                    report_mismatch("pull_two_z", got.pull_two_z, exp.pull_two_z);
                if (got.coincident !== exp.coincident)
                    report_mismatch("coincident", got.coincident, exp.coincident);
                if (got.saturated !== exp.saturated)
                    report_mismatch("saturated", got.saturated, exp.saturated);
            end
        endtask

        task report_mismatch(string what, logic [FORCE_W-1:0] got, logic [FORCE_W-1:0] exp);
            errors++;
            $display("%0t mismatch %s: got %h expected %h", $realtime, what, got, exp);
        endtask
    endclass

    logic i_clk = 1'b0;
    logic i_rst_n = 1'b0;
    logic start = 1'b0;
    logic busy;
    t_pair_in i_pair = '0;
    logic i_cfg_we = 1'b0;
    logic [GRAV_W-1:0] i_cfg_wdata = '0;
    logic o_valid;
    t_pair_out o_result;

    force_scoreboard board;
    int idle_cycles;
    bit gaps_on;

    always #5 i_clk = ~i_clk;

    pairwise_gravity_force u_dut (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .start      (start),
        .busy       (busy),
        .i_pair     (i_pair),
        .i_cfg_we   (i_cfg_we),
        .i_cfg_wdata(i_cfg_wdata),
        .o_valid    (o_valid),
        .o_result   (o_result)
    );

    // Result beats cannot be held off, so every strobe is checked at the edge.
    always @(posedge i_clk) begin
        if (i_rst_n && o_valid)
            board.check_force(o_result);
    end

    // The watchdog counts cycles in which no beat moves either way.
    always @(posedge i_clk) begin
        if (!i_rst_n || (start && !busy) || o_valid)
            idle_cycles <= 0;
        else
            idle_cycles <= idle_cycles + 1;
        if (idle_cycles >= WATCHDOG_LIMIT) begin
            $display("[FAIL] regression broken");
            $finish;
        end
    end

    // Offers one pair, holds it until taken, and may leave a random gap after.
    // Start stays high across back-to-back beats to avoid a double assignment.
    task send_pair(t_pair_in p);
        start <= 1'b1;
        i_pair <= p;
        @(posedge i_clk);
        while (busy) @(posedge i_clk);
        board.note_pair(p);
        if (gaps_on && $urandom_range(99) < 8) begin
            start <= 1'b0;
            repeat ($urandom_range(4, 1)) @(posedge i_clk);
        end
    endtask

    task settle();
        start <= 1'b0;
        @(posedge i_clk);
        while (board.pending_forces.size() != 0) @(posedge i_clk);
        repeat (DRAIN_CYCLES) @(posedge i_clk);
    endtask

    task write_grav(logic [GRAV_W-1:0] g);
        i_cfg_we <= 1'b1;
        i_cfg_wdata <= g;
        @(posedge i_clk);
        i_cfg_we <= 1'b0;
        board.grav = g;
    endtask

    function automatic logic [POS_W-1:0] rand_pos();
        case ($urandom_range(3))
            0: return $urandom();
            1: return $urandom_range(2000) - 1000;
            2: return 32'({8'($urandom_range(255)), 16'h0}) - 32'h0080_0000
                      + $urandom_range(65535);
            default: return $urandom_range(3) == 0 ? 32'h8000_0000 : 32'h7fff_ffff;
        endcase
    endfunction

    function automatic logic [MASS_W-1:0] rand_mass();
        case ($urandom_range(3))
            0: return $urandom();
            1: return $urandom_range(1 << 20);
            2: return 32'hffff_ffff;
            default: return 32'h0001_0000;
        endcase
    endfunction

    function automatic t_pair_in rand_pair();
        t_pair_in p;
        p.first_x = rand_pos();
        p.first_y = rand_pos();
        p.first_z = rand_pos();
        p.first_mass = rand_mass();
        p.second_x = rand_pos();
        p.second_y = rand_pos();
        p.second_z = rand_pos();
        p.second_mass = rand_mass();
        // Near neighbors and exact coincidence are worth hitting often.
        if ($urandom_range(9) == 0) begin
            p.second_x = p.first_x;
            p.second_y = p.first_y;
            p.second_z = p.first_z + ($urandom_range(1) ? $urandom_range(3) : 0);
        end
        return p;
    endfunction

    function automatic t_pair_in make_pair(int x1, int y1, int z1, logic [31:0] m1,
                                           int x2, int y2, int z2, logic [31:0] m2);
        t_pair_in p;
        p.first_x = x1; p.first_y = y1; p.first_z = z1; p.first_mass = m1;
        p.second_x = x2; p.second_y = y2; p.second_z = z2; p.second_mass = m2;
        return p;
    endfunction

    initial begin
        logic [GRAV_W-1:0] grav_steps[5];
        board = new();
        board.grav = GRAV_RESET;
        gaps_on = 1'b0;
        repeat (9) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        // Directed beats at the reset value of G.
        send_pair(make_pair(0, 0, 0, 32'h10000, 32'h10000, 0, 0, 32'h10000));
        send_pair(make_pair(0, 0, 0, 32'h10000, 0, -32'h10000, 0, 32'h10000));
        send_pair(make_pair(5, 6, 7, 32'h10000, 5, 6, 7, 32'hffffffff));
        send_pair(make_pair(0, 0, 0, 32'hffffffff, 1, 0, 0, 32'hffffffff));
        send_pair(make_pair(0, 0, 0, 32'hffffffff, 0, 0, -1, 32'hffffffff));
        send_pair(make_pair(0, 0, 0, 0, 32'h30000, 32'h40000, 0, 32'h10000));
        send_pair(make_pair(32'h80000000, 32'h80000000, 32'h80000000, 32'hffffffff,
                            32'h7fffffff, 32'h7fffffff, 32'h7fffffff, 32'hffffffff));
        send_pair(make_pair(32'h7fffffff, 32'h80000000, 0, 32'h10000,
                            32'h80000000, 32'h7fffffff, 1, 32'h10000));
        send_pair(make_pair(32'h10000, 32'h20000, -32'h30000, 32'h50000,
                            -32'h10000, 32'h20000, 32'h30000, 32'h80000));
        send_pair(make_pair(-1, -1, -1, 32'h1, 1, 1, 1, 32'h1));
        settle();

        // Zero G and the largest G, then random traffic under several settings.
        write_grav('0);
        send_pair(make_pair(0, 0, 0, 32'hffffffff, 1, 1, 1, 32'hffffffff));
        settle();
        write_grav(32'hffffffff);
        send_pair(make_pair(0, 0, 0, 32'h10000, 32'h1000000, 0, 0, 32'h10000));
        send_pair(make_pair(0, 0, 0, 32'hffffffff, 32'h7fffffff, 0, 0, 32'hffffffff));
        settle();

        grav_steps = '{32'h0000_0001, 32'hffff_ffff, 32'h0000_0000,
                       32'h0001_0000, 32'h0000_0012};
        for (int phase = 0; phase < 5; phase++) begin
            write_grav(phase == 4 ? $urandom() : grav_steps[phase]);
            for (int n = 0; n < 220; n++) begin
                // The first stretch of each phase runs flat out with no gaps.
                gaps_on = (n >= 60);
                send_pair(rand_pair());
            end
            settle();
        end

        if (board.errors == 0 && board.pending_forces.size() == 0) begin
            $display("[ OK ] regression clean");
        end else begin
            $display("[FAIL] regression broken");
        end
        $finish;
    end

endmodule
